// File: rtl/aoc_pkg.sv
// ----------------------------------------------------------------------------
// AABB/OBB collision package
// Shared codes and constants of the separating-axis collision core.
// ----------------------------------------------------------------------------
package aoc_pkg;

  typedef enum logic [1:0] {
    REG_BOX_MIN_X = 2'd0,
    REG_BOX_MIN_Y = 2'd1,
    REG_BOX_MAX_X = 2'd2,
    REG_BOX_MAX_Y = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    SLOT_BOX_POS = 3'd0,
    SLOT_OBB_POS = 3'd1,
    SLOT_CORNER0 = 3'd2,
    SLOT_CORNER1 = 3'd3,
    SLOT_CORNER2 = 3'd4,
    SLOT_CORNER3 = 3'd5,
    SLOT_AXIS0   = 3'd6,
    SLOT_AXIS1   = 3'd7
  } slot_e;

  localparam int unsigned SLOT_WIDTH = 3;
  localparam int unsigned PEN_WIDTH  = 31;

endpackage

// File: rtl/aoc_front.sv
// ----------------------------------------------------------------------------
// AABB/OBB collision front end
// Holds the configuration and the load slots, and forms the job word of a test.
// ----------------------------------------------------------------------------
module aoc_front #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int JOB_WIDTH   = 16 * COORD_WIDTH + 4 * (FRAC_BITS + 2)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 fire_i,
  input  aoc_pkg::slot_e                       slot_i,
  input  logic signed [COORD_WIDTH-1:0]        vec_x_i,
  input  logic signed [COORD_WIDTH-1:0]        vec_y_i,
  input  logic                                 cfg_we_i,
  input  aoc_pkg::reg_idx_e                    cfg_idx_i,
  input  logic signed [COORD_WIDTH-1:0]        cfg_data_i,
  output logic [JOB_WIDTH-1:0]                 job_o
);
  import aoc_pkg::*;

  localparam int AW = FRAC_BITS + 2;
  localparam int CW = ((COORD_WIDTH > AW) ? COORD_WIDTH : AW) + 1;
  localparam logic signed [CW-1:0] ONE_C  = $signed(CW'(1) << FRAC_BITS);
  localparam logic signed [CW-1:0] MONE_C = -ONE_C;

  logic signed [COORD_WIDTH-1:0] bminx_q, bminy_q, bmaxx_q, bmaxy_q;
  logic signed [COORD_WIDTH-1:0] bpx_q, bpy_q, opx_q, opy_q;
  logic signed [COORD_WIDTH-1:0] bpx_d, bpy_d, opx_d, opy_d;
  logic signed [COORD_WIDTH-1:0] cx_q [4];
  logic signed [COORD_WIDTH-1:0] cy_q [4];
  logic signed [COORD_WIDTH-1:0] cx_d [4];
  logic signed [COORD_WIDTH-1:0] cy_d [4];
  logic signed [AW-1:0]          ax_q [2];
  logic signed [AW-1:0]          ay_q [2];
  logic signed [AW-1:0]          ax_d [2];
  logic signed [AW-1:0]          ay_d [2];
  logic signed [CW-1:0]          ext_x, ext_y;
  logic signed [AW-1:0]          clx, cly;
  logic [1:0]                    c_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bminx_q <= '0;
      bminy_q <= '0;
      bmaxx_q <= '0;
      bmaxy_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BOX_MIN_X: bminx_q <= cfg_data_i;
        REG_BOX_MIN_Y: bminy_q <= cfg_data_i;
        REG_BOX_MAX_X: bmaxx_q <= cfg_data_i;
        REG_BOX_MAX_Y: bmaxy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    ext_x = CW'(vec_x_i);
    ext_y = CW'(vec_y_i);
    if (ext_x > ONE_C) begin
      clx = AW'(ONE_C);
    end else if (ext_x < MONE_C) begin
      clx = AW'(MONE_C);
    end else begin
      clx = AW'(ext_x);
    end
    if (ext_y > ONE_C) begin
      cly = AW'(ONE_C);
    end else if (ext_y < MONE_C) begin
      cly = AW'(MONE_C);
    end else begin
      cly = AW'(ext_y);
    end
  end

  assign c_idx = 2'(slot_i - SLOT_CORNER0);

  always_comb begin
    bpx_d = bpx_q;
    bpy_d = bpy_q;
    opx_d = opx_q;
    opy_d = opy_q;
    cx_d  = cx_q;
    cy_d  = cy_q;
    ax_d  = ax_q;
    ay_d  = ay_q;
    if (fire_i) begin
      case (slot_i) inside
        SLOT_BOX_POS: begin
          bpx_d = vec_x_i;
          bpy_d = vec_y_i;
        end
        SLOT_OBB_POS: begin
          opx_d = vec_x_i;
          opy_d = vec_y_i;
        end
        [SLOT_CORNER0:SLOT_CORNER3]: begin
          cx_d[c_idx] = vec_x_i;
          cy_d[c_idx] = vec_y_i;
        end
        default: begin
          ax_d[slot_i[0]] = clx;
          ay_d[slot_i[0]] = cly;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    bpx_q <= bpx_d;
    bpy_q <= bpy_d;
    opx_q <= opx_d;
    opy_q <= opy_d;
    cx_q  <= cx_d;
    cy_q  <= cy_d;
    ax_q  <= ax_d;
    ay_q  <= ay_d;
  end

  assign job_o = {bminx_q, bminy_q, bmaxx_q, bmaxy_q, bpx_d, bpy_d, opx_d, opy_d,
                  cx_d[0], cy_d[0], cx_d[1], cy_d[1], cx_d[2], cy_d[2],
                  cx_d[3], cy_d[3], ax_d[0], ay_d[0], ax_d[1], ay_d[1]};

endmodule

// File: rtl/aoc_queue.sv
// ----------------------------------------------------------------------------
// AABB/OBB collision job queue
// One-entry buffer that holds a captured test between front and back end.
// ----------------------------------------------------------------------------
module aoc_queue #(
  parameter int DATA_WIDTH = 512
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [DATA_WIDTH-1:0] data_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output logic [DATA_WIDTH-1:0] data_o
);
  import aoc_pkg::*;

  logic                  full_q;
  logic [DATA_WIDTH-1:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (push_i) begin
      full_q <= 1'b1;
    end else if (pop_i) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign full_o = full_q;
  assign data_o = data_q;

endmodule

// File: rtl/aoc_back.sv
// ----------------------------------------------------------------------------
// AABB/OBB collision back end
// Runs the projections on a shared multiplier and forms the result word.
// ----------------------------------------------------------------------------
module aoc_back #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int JOB_WIDTH   = 16 * COORD_WIDTH + 4 * (FRAC_BITS + 2)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  job_valid_i,
  input  logic [JOB_WIDTH-1:0]                  job_i,
  output logic                                  job_pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  hit_o,
  output logic signed [FRAC_BITS+1:0]           normal_x_o,
  output logic signed [FRAC_BITS+1:0]           normal_y_o,
  output logic [aoc_pkg::PEN_WIDTH-1:0]         penetration_o,
  output logic signed [COORD_WIDTH-1:0]         new_pos_x_o,
  output logic signed [COORD_WIDTH-1:0]         new_pos_y_o
);
  import aoc_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int AW  = F + 2;
  localparam int VW  = W + 1;
  localparam int PW  = W + 3;
  localparam int MA  = PW + 1;
  localparam int PRW = MA + AW;
  localparam int SW  = PRW + 1;
  localparam int LW  = (MA > 32) ? MA : 32;
  localparam logic signed [AW-1:0]   ONE_A = $signed(AW'(1) << F);
  localparam logic signed [PW+1:0]   CMAX  = $signed({{(PW-W+3){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [PW+1:0]   CMIN  = $signed({{(PW-W+3){1'b1}}, {(W-1){1'b0}}});
  localparam logic signed [LW-1:0]   PMAX  =
    $signed({{(LW-PEN_WIDTH){1'b0}}, {PEN_WIDTH{1'b1}}});

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_MX   = 13'b0000000000010,
    S_MY   = 13'b0000000000100,
    S_ACC  = 13'b0000000001000,
    S_CHK  = 13'b0000000010000,
    S_NSEL = 13'b0000000100000,
    S_FX   = 13'b0000001000000,
    S_FY   = 13'b0000010000000,
    S_FS   = 13'b0000100000000,
    S_CX   = 13'b0001000000000,
    S_CY   = 13'b0010000000000,
    S_DONE = 13'b0100000000000,
    S_SPARE = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic signed [W-1:0]  j_minx, j_miny, j_maxx, j_maxy, j_bpx, j_bpy, j_opx, j_opy;
  logic signed [W-1:0]  j_cx [4];
  logic signed [W-1:0]  j_cy [4];
  logic signed [AW-1:0] j_ax [2];
  logic signed [AW-1:0] j_ay [2];

  logic signed [VW-1:0] va_x_q [4];
  logic signed [VW-1:0] va_y_q [4];
  logic signed [VW-1:0] vb_x_q [4];
  logic signed [VW-1:0] vb_y_q [4];
  logic signed [AW-1:0] oax_q [2];
  logic signed [AW-1:0] oay_q [2];
  logic signed [W-1:0]  px_q, py_q;
  logic signed [VW-1:0] dx_q, dy_q;

  logic [2:0]           v_q;
  logic [1:0]           k_q;
  logic [1:0]           nk_q;
  logic                 hit_q;
  logic signed [PW-1:0] mina_q, maxa_q, minb_q, maxb_q;
  logic signed [MA-1:0] pen_q;
  logic signed [AW-1:0] nx_q, ny_q;
  logic signed [PRW-1:0] prod_q, part_q;

  logic signed [MA-1:0]  mul_a;
  logic signed [AW-1:0]  mul_b;
  logic signed [PRW-1:0] prod;
  logic signed [SW-1:0]  sum;
  logic signed [PW-1:0]  proj;
  logic signed [VW-1:0]  vx, vy;
  logic signed [AW-1:0]  ax_s, ay_s;
  logic signed [PW-1:0]  omax, omin;
  logic signed [MA-1:0]  ov;
  logic                  sep, better;
  logic signed [MA-1:0]  corr_x, corr_y;
  logic signed [PW+1:0]  nposx, nposy;
  logic signed [LW-1:0]  pen_ext;
  logic                  out_free;

  logic                    out_valid_q;
  logic                    o_hit_q;
  logic signed [AW-1:0]    o_nx_q, o_ny_q;
  logic [PEN_WIDTH-1:0]    o_pen_q;
  logic signed [W-1:0]     o_px_q, o_py_q;

  assign {j_minx, j_miny, j_maxx, j_maxy, j_bpx, j_bpy, j_opx, j_opy,
          j_cx[0], j_cy[0], j_cx[1], j_cy[1], j_cx[2], j_cy[2], j_cx[3], j_cy[3],
          j_ax[0], j_ay[0], j_ax[1], j_ay[1]} = job_i;

  assign job_pop_o = (state_q == S_IDLE) && job_valid_i;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    case (k_q)
      2'd0: begin
        ax_s = ONE_A;
        ay_s = '0;
      end
      2'd1: begin
        ax_s = '0;
        ay_s = ONE_A;
      end
      2'd2: begin
        ax_s = oax_q[0];
        ay_s = oay_q[0];
      end
      default: begin
        ax_s = oax_q[1];
        ay_s = oay_q[1];
      end
    endcase
  end

  assign vx = v_q[2] ? vb_x_q[v_q[1:0]] : va_x_q[v_q[1:0]];
  assign vy = v_q[2] ? vb_y_q[v_q[1:0]] : va_y_q[v_q[1:0]];

  always_comb begin
    case (state_q)
      S_MX: begin
        mul_a = MA'(vx);
        mul_b = ax_s;
      end
      S_MY: begin
        mul_a = MA'(vy);
        mul_b = ay_s;
      end
      S_FX: begin
        mul_a = MA'(dx_q);
        mul_b = nx_q;
      end
      S_FY: begin
        mul_a = MA'(dy_q);
        mul_b = ny_q;
      end
      S_CX: begin
        mul_a = pen_q;
        mul_b = nx_q;
      end
      default: begin
        mul_a = pen_q;
        mul_b = ny_q;
      end
    endcase
  end

  assign prod = PRW'(mul_a) * PRW'(mul_b);
  assign sum  = SW'(part_q) + SW'(prod_q);
  assign proj = $signed(sum[F+PW-1:F]);

  assign omax   = (maxa_q < maxb_q) ? maxa_q : maxb_q;
  assign omin   = (mina_q > minb_q) ? mina_q : minb_q;
  assign ov     = MA'(omax) - MA'(omin);
  assign sep    = (maxa_q < minb_q) || (maxb_q < mina_q);
  assign better = (k_q == 2'd0) || (ov < pen_q);

  assign corr_x  = $signed(part_q[F+MA-1:F]);
  assign corr_y  = $signed(prod_q[F+MA-1:F]);
  assign nposx   = (PW+2)'(px_q) + (PW+2)'(corr_x);
  assign nposy   = (PW+2)'(py_q) + (PW+2)'(corr_y);
  assign pen_ext = LW'(pen_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          state_d = S_MX;
        end
      end
      S_MX:  state_d = S_MY;
      S_MY:  state_d = S_ACC;
      S_ACC: state_d = (v_q == 3'd7) ? S_CHK : S_MX;
      S_CHK: begin
        if (sep) begin
          state_d = S_DONE;
        end else if (k_q == 2'd3) begin
          state_d = S_NSEL;
        end else begin
          state_d = S_MX;
        end
      end
      S_NSEL: state_d = S_FX;
      S_FX:   state_d = S_FY;
      S_FY:   state_d = S_FS;
      S_FS:   state_d = S_CX;
      S_CX:   state_d = S_CY;
      S_CY:   state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        va_x_q[0] <= VW'(j_minx) + VW'(j_bpx);
        va_y_q[0] <= VW'(j_miny) + VW'(j_bpy);
        va_x_q[1] <= VW'(j_maxx) + VW'(j_bpx);
        va_y_q[1] <= VW'(j_miny) + VW'(j_bpy);
        va_x_q[2] <= VW'(j_maxx) + VW'(j_bpx);
        va_y_q[2] <= VW'(j_maxy) + VW'(j_bpy);
        va_x_q[3] <= VW'(j_minx) + VW'(j_bpx);
        va_y_q[3] <= VW'(j_maxy) + VW'(j_bpy);
        for (int i = 0; i < 4; i++) begin
          vb_x_q[i] <= VW'(j_cx[i]) + VW'(j_opx);
          vb_y_q[i] <= VW'(j_cy[i]) + VW'(j_opy);
        end
        oax_q <= j_ax;
        oay_q <= j_ay;
        px_q  <= j_bpx;
        py_q  <= j_bpy;
        dx_q  <= VW'(j_opx) - VW'(j_bpx);
        dy_q  <= VW'(j_opy) - VW'(j_bpy);
        v_q   <= '0;
        k_q   <= '0;
        hit_q <= 1'b1;
      end
      S_MX, S_FX, S_CX: begin
        prod_q <= prod;
      end
      S_MY, S_FY, S_CY: begin
        prod_q <= prod;
        part_q <= prod_q;
      end
      S_ACC: begin
        if (v_q[2]) begin
          if (v_q[1:0] == 2'd0 || proj < minb_q) begin
            minb_q <= proj;
          end
          if (v_q[1:0] == 2'd0 || proj > maxb_q) begin
            maxb_q <= proj;
          end
        end else begin
          if (v_q[1:0] == 2'd0 || proj < mina_q) begin
            mina_q <= proj;
          end
          if (v_q[1:0] == 2'd0 || proj > maxa_q) begin
            maxa_q <= proj;
          end
        end
        v_q <= v_q + 3'd1;
      end
      S_CHK: begin
        if (sep) begin
          hit_q <= 1'b0;
        end else begin
          if (better) begin
            pen_q <= ov;
            nk_q  <= k_q;
          end
          k_q <= (k_q == 2'd3) ? (better ? k_q : nk_q) : k_q + 2'd1;
        end
      end
      S_NSEL: begin
        nx_q <= ax_s;
        ny_q <= ay_s;
      end
      S_FS: begin
        if (!sum[SW-1] && (sum != '0)) begin
          nx_q <= -nx_q;
          ny_q <= -ny_q;
        end
      end
      S_DONE: begin
        if (out_free) begin
          o_hit_q <= hit_q;
          if (hit_q) begin
            o_nx_q  <= nx_q;
            o_ny_q  <= ny_q;
            o_pen_q <= (pen_ext > PMAX) ? PMAX[PEN_WIDTH-1:0] : pen_ext[PEN_WIDTH-1:0];
            o_px_q  <= (nposx > CMAX) ? W'(CMAX) : ((nposx < CMIN) ? W'(CMIN) : W'(nposx));
            o_py_q  <= (nposy > CMAX) ? W'(CMAX) : ((nposy < CMIN) ? W'(CMIN) : W'(nposy));
          end else begin
            o_nx_q  <= '0;
            o_ny_q  <= '0;
            o_pen_q <= '0;
            o_px_q  <= px_q;
            o_py_q  <= py_q;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = o_hit_q;
  assign normal_x_o    = o_nx_q;
  assign normal_y_o    = o_ny_q;
  assign penetration_o = o_pen_q;
  assign new_pos_x_o   = o_px_q;
  assign new_pos_y_o   = o_py_q;

endmodule

// File: rtl/aabb_obb_sat_collision_core.sv
// ----------------------------------------------------------------------------
// AABB/OBB separating-axis collision core
// Loads one box and one oriented box, then tests them for overlap in 2D.
// ----------------------------------------------------------------------------
// Load words fill the slots of a test. A word marked last queues the test, and
// the single shared multiplier forms two products for each of eight corners on
// each axis tested, up to four axes, and stops at the first separating axis;
// on a hit it also forms the normal direction and the position correction.
// Load words for the next test are taken while a test runs; a further last
// word waits until the one-entry job queue has room.
module aabb_obb_sat_collision_core #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  aoc_pkg::slot_e                        in_slot_i,
  input  logic signed [COORD_WIDTH-1:0]         in_vec_x_i,
  input  logic signed [COORD_WIDTH-1:0]         in_vec_y_i,
  input  logic                                  in_last_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  out_hit_o,
  output logic signed [FRAC_BITS+1:0]           out_normal_x_o,
  output logic signed [FRAC_BITS+1:0]           out_normal_y_o,
  output logic [aoc_pkg::PEN_WIDTH-1:0]         out_penetration_o,
  output logic signed [COORD_WIDTH-1:0]         out_new_pos_x_o,
  output logic signed [COORD_WIDTH-1:0]         out_new_pos_y_o,
  input  logic                                  cfg_we_i,
  input  aoc_pkg::reg_idx_e                     cfg_idx_i,
  input  logic signed [COORD_WIDTH-1:0]         cfg_data_i
);
  import aoc_pkg::*;

  localparam int JW = 16 * COORD_WIDTH + 4 * (FRAC_BITS + 2);

  logic          fire, q_push, q_pop, q_full;
  logic [JW-1:0] job_in, job_out;

  assign in_stall_o = in_last_i && q_full && !q_pop;
  assign fire       = in_valid_i && !in_stall_o;
  assign q_push     = fire && in_last_i;

  aoc_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .JOB_WIDTH  (JW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .slot_i    (in_slot_i),
    .vec_x_i   (in_vec_x_i),
    .vec_y_i   (in_vec_y_i),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .job_o     (job_in)
  );

  aoc_queue #(
    .DATA_WIDTH(JW)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .data_i(job_in),
    .pop_i (q_pop),
    .full_o(q_full),
    .data_o(job_out)
  );

  aoc_back #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .JOB_WIDTH  (JW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (q_full),
    .job_i        (job_out),
    .job_pop_o    (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (out_hit_o),
    .normal_x_o   (out_normal_x_o),
    .normal_y_o   (out_normal_y_o),
    .penetration_o(out_penetration_o),
    .new_pos_x_o  (out_new_pos_x_o),
    .new_pos_y_o  (out_new_pos_y_o)
  );

`ifndef ASSERT_OFF
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full && !q_pop |-> !q_push)
    else $error("Job pushed into a full queue.");

  a_stall_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_last_i && q_full)
    else $error("Load word stalled without a pending job.");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_hit_o |->
      out_normal_x_o == '0 && out_normal_y_o == '0 && out_penetration_o == '0)
    else $error("Miss result carries a normal or depth.");
`endif

endmodule

// File: verif/aabb_obb_sat_collision_core_tb.sv
// ----------------------------------------------------------------------------
// AABB/OBB collision core testbench
// Loads random and directed box pairs through the load port, sweeps the box
// extent registers and the idle/stall patterns of both channels, and checks
// every collision result against a fixed-point separating-axis predictor.
// ----------------------------------------------------------------------------
module aabb_obb_sat_collision_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aoc_pkg::*;

  localparam longint ONE_Q     = 64'sd65536;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam int     SETTLE    = 150;

  typedef struct packed {
    logic        hit;
    logic [17:0] normal_x;
    logic [17:0] normal_y;
    logic [30:0] penetration;
    logic [31:0] new_pos_x;
    logic [31:0] new_pos_y;
  } collision_t;

  class collision_scoreboard;
    longint     extent[4];
    longint     box_px, box_py, obb_px, obb_py;
    longint     corner_x[4], corner_y[4];
    longint     axis_x[2], axis_y[2];
    collision_t pending[$];
    int         errors;

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void set_extent(reg_idx_e idx, logic signed [31:0] v);
      extent[idx] = v;
    endfunction

    function void note_load(slot_e s, logic signed [31:0] x, logic signed [31:0] y,
                            logic last);
      longint     ax[4], ay[4], va_x[4], va_y[4], vb_x[4], vb_y[4];
      longint     mina, maxa, minb, maxb, p, ov, pen, nx, ny, d, px, py;
      bit         hit, have;
      collision_t r;
      case (s)
        SLOT_BOX_POS: begin box_px = x; box_py = y; end
        SLOT_OBB_POS: begin obb_px = x; obb_py = y; end
        SLOT_AXIS0, SLOT_AXIS1: begin
          axis_x[s - SLOT_AXIS0] = clamp(x, -ONE_Q, ONE_Q);
          axis_y[s - SLOT_AXIS0] = clamp(y, -ONE_Q, ONE_Q);
        end
        default: begin
          corner_x[s - SLOT_CORNER0] = x;
          corner_y[s - SLOT_CORNER0] = y;
        end
      endcase
      if (!last) return;
      va_x[0] = extent[REG_BOX_MIN_X] + box_px; va_y[0] = extent[REG_BOX_MIN_Y] + box_py;
      va_x[1] = extent[REG_BOX_MAX_X] + box_px; va_y[1] = extent[REG_BOX_MIN_Y] + box_py;
      va_x[2] = extent[REG_BOX_MAX_X] + box_px; va_y[2] = extent[REG_BOX_MAX_Y] + box_py;
      va_x[3] = extent[REG_BOX_MIN_X] + box_px; va_y[3] = extent[REG_BOX_MAX_Y] + box_py;
      for (int i = 0; i < 4; i++) begin
        vb_x[i] = corner_x[i] + obb_px;
        vb_y[i] = corner_y[i] + obb_py;
      end
      ax[0] = ONE_Q; ay[0] = 0; ax[1] = 0; ay[1] = ONE_Q;
      ax[2] = axis_x[0]; ay[2] = axis_y[0]; ax[3] = axis_x[1]; ay[3] = axis_y[1];
      hit = 1; have = 0; pen = 0; nx = 0; ny = 0;
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 4; k++) begin
          p = (va_x[k] * ax[i] + va_y[k] * ay[i]) >>> 16;
          if (k == 0 || p < mina) mina = p;
          if (k == 0 || p > maxa) maxa = p;
          p = (vb_x[k] * ax[i] + vb_y[k] * ay[i]) >>> 16;
          if (k == 0 || p < minb) minb = p;
          if (k == 0 || p > maxb) maxb = p;
        end
        if (maxa < minb || maxb < mina) begin
          hit = 0;
          break;
        end
        ov = (maxa < maxb ? maxa : maxb) - (mina > minb ? mina : minb);
        if (!have || ov < pen) begin
          have = 1; pen = ov; nx = ax[i]; ny = ay[i];
        end
      end
      px = box_px; py = box_py;
      if (hit) begin
        d = (obb_px - box_px) * nx + (obb_py - box_py) * ny;
        if (d > 0) begin nx = -nx; ny = -ny; end
        px = clamp(px + ((pen * nx) >>> 16), COORD_MIN, COORD_MAX);
        py = clamp(py + ((pen * ny) >>> 16), COORD_MIN, COORD_MAX);
        pen = clamp(pen, 0, 64'sd2147483647);
      end else begin
        nx = 0; ny = 0; pen = 0;
      end
      r.hit = hit; r.normal_x = nx[17:0]; r.normal_y = ny[17:0];
      r.penetration = pen[30:0]; r.new_pos_x = px[31:0]; r.new_pos_y = py[31:0];
      pending.push_back(r);
    endfunction

    function void check_result(collision_t got);
      collision_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: hit %0d/%0d nx %h/%h ny %h/%h pen %h/%h px %h/%h py %h/%h",
                   want.hit, got.hit, want.normal_x, got.normal_x, want.normal_y,
                   got.normal_y, want.penetration, got.penetration, want.new_pos_x,
                   got.new_pos_x, want.new_pos_y, got.new_pos_y);
      end
    endfunction
  endclass

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              in_valid_i = 0;
  logic              in_stall_o;
  slot_e             in_slot_i = SLOT_BOX_POS;
  logic signed [31:0] in_vec_x_i = '0;
  logic signed [31:0] in_vec_y_i = '0;
  logic              in_last_i = 0;
  logic              out_valid_o;
  logic              out_stall_i = 0;
  logic              out_hit_o;
  logic signed [17:0] out_normal_x_o, out_normal_y_o;
  logic [30:0]       out_penetration_o;
  logic signed [31:0] out_new_pos_x_o, out_new_pos_y_o;
  logic              cfg_we_i = 0;
  reg_idx_e          cfg_idx_i = REG_BOX_MIN_X;
  logic signed [31:0] cfg_data_i = '0;

  collision_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int words_sent = 0;

  aabb_obb_sat_collision_core u_dut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({out_hit_o, out_normal_x_o, out_normal_y_o, out_penetration_o,
                       out_new_pos_x_o, out_new_pos_y_o});
  end

  task automatic send_word(slot_e s, logic [31:0] x, logic [31:0] y, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i = 0;
    end
    @(negedge clk_i);
    in_valid_i = 1; in_slot_i = s; in_vec_x_i = x; in_vec_y_i = y; in_last_i = last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_load(s, x, y, last);
    words_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_extents(logic [31:0] mnx, logic [31:0] mny,
                               logic [31:0] mxx, logic [31:0] mxy);
    logic [31:0] v[4];
    v = '{mnx, mny, mxx, mxy};
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we_i = 1; cfg_idx_i = reg_idx_e'(i); cfg_data_i = v[i];
      sb.set_extent(reg_idx_e'(i), v[i]);
    end
    @(negedge clk_i);
    cfg_we_i = 0;
  endtask

  function automatic logic [31:0] rand_vec(slot_e s);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) return $urandom();
    if (s >= SLOT_AXIS0) begin
      if (sel < 15) return 32'sd0;
      if (sel < 25) return $urandom_range(1) ? 32'sd65536 : -32'sd65536;
      return $signed($urandom_range(131072)) - 65536;
    end
    if (s >= SLOT_CORNER0) return $signed($urandom_range(12 << 16)) - (6 << 16);
    return $signed($urandom_range(40 << 16)) - (20 << 16);
  endfunction

  task automatic run_query(bit full);
    slot_e order[8];
    int    n;
    if (full) begin
      for (int i = 0; i < 8; i++) order[i] = slot_e'(i);
      order.shuffle();
      n = 8;
    end else begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) order[i] = slot_e'($urandom_range(7));
    end
    for (int i = 0; i < n; i++)
      send_word(order[i], rand_vec(order[i]), rand_vec(order[i]),
                (i == n - 1) ? 1'b1 : ($urandom_range(99) < 3));
  endtask

  initial begin
    #20ms;
    $display("aabb_obb_sat_collision_core test failed");
    $finish;
  end

  initial begin
    int modes[4][2];
    modes = '{'{0, 0}, '{75, 0}, '{0, 75}, '{16, 16}};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    write_extents(-32'sd131072, -32'sd131072, 32'sd131072, 32'sd131072);
    send_word(SLOT_BOX_POS, 32'sd0, 32'sd0, 0);
    send_word(SLOT_OBB_POS, 32'sd196608, 32'sd65536, 0);
    send_word(SLOT_CORNER0, -32'sd65536, -32'sd65536, 0);
    send_word(SLOT_CORNER1, 32'sd65536, -32'sd65536, 0);
    send_word(SLOT_CORNER2, 32'sd65536, 32'sd65536, 0);
    send_word(SLOT_CORNER3, -32'sd65536, 32'sd65536, 0);
    send_word(SLOT_AXIS0, 32'sd65536, 32'sd0, 0);
    send_word(SLOT_AXIS1, 32'sd0, -32'sd65536, 1);
    send_word(SLOT_AXIS0, 32'sd0, 32'sd0, 1);
    send_word(SLOT_AXIS1, 32'h7fffffff, 32'h80000000, 1);
    send_word(SLOT_AXIS0, 32'sd46341, 32'sd46341, 1);
    send_word(SLOT_BOX_POS, 32'sd20 << 16, 32'sd0, 1);
    send_word(SLOT_BOX_POS, 32'h7fff0000, 32'h80010000, 0);
    send_word(SLOT_OBB_POS, 32'h7ffe8000, 32'h80008000, 1);
    send_word(SLOT_CORNER0, 32'h80000000, 32'h7fffffff, 1);
    send_word(SLOT_CORNER1, 32'hffffffff, 32'h00000001, 1);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: write_extents($urandom_range(3 << 16) * -1, $urandom_range(3 << 16) * -1,
                         $urandom_range(3 << 16), $urandom_range(3 << 16));
        1: write_extents(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        2: write_extents(32'sd0, 32'sd0, 32'sd0, 32'sd0);
        default: write_extents($urandom(), $urandom(), $urandom(), $urandom());
      endcase
      send_idle_pct  = modes[ph % 4][0];
      recv_stall_pct = modes[ph % 4][1];
      for (int q = 0; q < 9; q++) begin
        run_query($urandom_range(99) < 70);
        if (q == 4 && ph == 2) wait_drained();
      end
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("aabb_obb_sat_collision_core test passed");
    else
      $display("aabb_obb_sat_collision_core test failed");
    $finish;
  end

endmodule
